### rtl/dtq_pkg.sv
// ----------------------------------------------------------------------------
// dtq_pkg
// Shared types, constants and pointer helpers for the deadline timer queue.
// ----------------------------------------------------------------------------
package dtq_pkg;

    // Queue geometry
    localparam int QUEUE_DEPTH = 16;
    localparam int MAX_OUT     = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W       = CNT_W + 1;
    localparam int RES_W       = $clog2(MAX_OUT + 1);

    // Field widths
    localparam int TIME_W   = 32;
    localparam int HANDLE_W = 16;
    localparam int S_DATA_W = 48;  // wakeup time, handle
    localparam int S_USER_W = 2;   // opcode, stop marker
    localparam int M_DATA_W = 16;  // handle
    localparam int M_USER_W = 2;   // status

    // Opcodes
    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Result status codes
    typedef enum logic [1:0] {
        STATUS_DUE  = 2'd0,
        STATUS_STOP = 2'd1,
        STATUS_FULL = 2'd2
    } status_t;

    // One queue entry as stored in memory
    typedef struct packed {
        logic [TIME_W-1:0]   wake_time;
        logic [HANDLE_W-1:0] handle;
        logic                stop;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_RD,
        ST_INS_CMP,
        ST_TICK_RD,
        ST_TICK_CHK,
        ST_FLUSH
    } state_t;

    // Circular pointer step forward
    function automatic logic [IDX_W-1:0] ptr_inc(input logic [IDX_W-1:0] p);
        logic [IDX_W-1:0] r;
        if (p == IDX_W'(QUEUE_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    // Circular pointer step backward
    function automatic logic [IDX_W-1:0] ptr_dec(input logic [IDX_W-1:0] p);
        logic [IDX_W-1:0] r;
        if (p == '0) begin
            r = IDX_W'(QUEUE_DEPTH - 1);
        end else begin
            r = p - 1'b1;
        end
        return r;
    endfunction

endpackage

### rtl/dtq_ram.sv
// ----------------------------------------------------------------------------
// dtq_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module dtq_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, data held while no read is issued
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/deadline_timer_queue_core.sv
// ----------------------------------------------------------------------------
// deadline_timer_queue_core
// Timer queue kept in wakeup order in a circular buffer held in one RAM.
// ----------------------------------------------------------------------------
// The block handles one input transaction at a time. Entries live in a single
// RAM as a circular buffer sorted by wakeup time, head at the earliest entry.
// An add is accepted, then every stored entry with a later wakeup moves up one
// slot through the single RAM read port (read, then compare and write back).
// The new entry then goes into the bottom slot when every stored entry was
// later, or behind an earlier entry once that one is read and compared. A full
// queue rejects an add with a full status. A tick reads and checks the head
// once per released entry, until an entry not yet due, a stop marker, an empty
// queue or the result budget ends the walk; the last result, if any, is flushed.
// Results leave through an output register, and each result is held back in a
// pending register so the last one of a tick can carry tlast. After a stop
// marker is released, every input transaction is taken and dropped until reset.
// ----------------------------------------------------------------------------
module deadline_timer_queue_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Input channel
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [dtq_pkg::S_DATA_W-1:0]  s_tdata,   // [31:0] time_value, [47:32] op_handle
    input  logic [dtq_pkg::S_USER_W-1:0]  s_tuser,   // [0] opcode, [1] stop_marker
    // Result channel
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [dtq_pkg::M_DATA_W-1:0]  m_tdata,   // [15:0] out_handle
    output logic [dtq_pkg::M_USER_W-1:0]  m_tuser,   // [1:0] status
    output logic                          m_tlast
);

    // Control state
    dtq_pkg::state_t                state_reg,   state_next;
    logic [dtq_pkg::IDX_W-1:0]      head_reg,    head_next;
    logic [dtq_pkg::CNT_W-1:0]      count_reg,   count_next;
    logic                           halted_reg,  halted_next;
    logic [dtq_pkg::IDX_W-1:0]      pos_reg,     pos_next;
    logic [dtq_pkg::CNT_W-1:0]      rem_reg,     rem_next;
    logic [dtq_pkg::RES_W-1:0]      res_cnt_reg, res_cnt_next;
    logic                           pend_valid_reg, pend_valid_next;
    logic                           m_tvalid_reg;

    // Payload
    dtq_pkg::entry_t                item_reg,    item_next;
    logic [dtq_pkg::HANDLE_W-1:0]   pend_handle_reg, pend_handle_next;
    dtq_pkg::status_t               pend_status_reg, pend_status_next;
    logic [dtq_pkg::HANDLE_W-1:0]   m_handle_reg;
    dtq_pkg::status_t               m_status_reg;
    logic                           m_last_reg;

    // RAM port signals
    logic                           ram_we;
    logic [dtq_pkg::IDX_W-1:0]      ram_waddr;
    dtq_pkg::entry_t                ram_wdata;
    logic                           ram_re;
    logic [dtq_pkg::IDX_W-1:0]      ram_raddr;
    dtq_pkg::entry_t                ram_rdata;

    // Output load request
    logic                           out_load;
    logic [dtq_pkg::HANDLE_W-1:0]   out_handle;
    dtq_pkg::status_t               out_status;
    logic                           out_last;
    logic                           out_free;

    // Decoded input fields
    logic                           in_opcode;
    logic                           in_stop;
    logic [dtq_pkg::TIME_W-1:0]     in_time;
    logic [dtq_pkg::HANDLE_W-1:0]   in_handle;

    // Tail slot of the circular buffer
    logic [dtq_pkg::SUM_W-1:0]      tail_sum;
    logic [dtq_pkg::IDX_W-1:0]      tail_idx;

    logic                           s_accept;
    logic                           head_due;

    assign in_opcode = s_tuser[0];
    assign in_stop   = s_tuser[1];
    assign in_time   = s_tdata[31:0];
    assign in_handle = s_tdata[47:32];

    assign s_tready = (state_reg == dtq_pkg::ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // Wrap head plus count back into the buffer
    always_comb begin
        tail_sum = dtq_pkg::SUM_W'(head_reg) + dtq_pkg::SUM_W'(count_reg);
        if (tail_sum >= dtq_pkg::SUM_W'(dtq_pkg::QUEUE_DEPTH)) begin
            tail_sum = tail_sum - dtq_pkg::SUM_W'(dtq_pkg::QUEUE_DEPTH);
        end
        tail_idx = tail_sum[dtq_pkg::IDX_W-1:0];
    end

    // A stop marker at the head is taken whether due or not
    assign head_due = ram_rdata.stop || (ram_rdata.wake_time <= item_reg.wake_time);

    dtq_ram #(
        .DATA_W (dtq_pkg::ENTRY_W),
        .DEPTH  (dtq_pkg::QUEUE_DEPTH)
    ) u_entry_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Next state and datapath control
    always_comb begin
        state_next       = state_reg;
        head_next        = head_reg;
        count_next       = count_reg;
        halted_next      = halted_reg;
        pos_next         = pos_reg;
        rem_next         = rem_reg;
        res_cnt_next     = res_cnt_reg;
        pend_valid_next  = pend_valid_reg;
        pend_handle_next = pend_handle_reg;
        pend_status_next = pend_status_reg;
        item_next        = item_reg;

        ram_we    = 1'b0;
        ram_waddr = pos_reg;
        ram_wdata = item_reg;
        ram_re    = 1'b0;
        ram_raddr = head_reg;

        out_load   = 1'b0;
        out_handle = pend_handle_reg;
        out_status = pend_status_reg;
        out_last   = 1'b0;

        case (state_reg)
            dtq_pkg::ST_IDLE: begin
                // Take a transaction; drop it once halted
                if (s_accept && !halted_reg) begin
                    if (in_opcode == dtq_pkg::OP_ADD) begin
                        if (count_reg == dtq_pkg::CNT_W'(dtq_pkg::QUEUE_DEPTH)) begin
                            pend_valid_next  = 1'b1;
                            pend_handle_next = in_handle;
                            pend_status_next = dtq_pkg::STATUS_FULL;
                            state_next       = dtq_pkg::ST_FLUSH;
                        end else begin
                            item_next.wake_time = in_time;
                            item_next.handle    = in_stop ? '0 : in_handle;
                            item_next.stop      = in_stop;
                            pos_next            = tail_idx;
                            rem_next            = count_reg;
                            state_next          = dtq_pkg::ST_INS_RD;
                        end
                    end else begin
                        item_next.wake_time = in_time;
                        res_cnt_next        = '0;
                        state_next          = dtq_pkg::ST_TICK_RD;
                    end
                end
            end

            dtq_pkg::ST_INS_RD: begin
                // Place the entry at the bottom, or fetch the one below the gap
                if (rem_reg == '0) begin
                    ram_we     = 1'b1;
                    count_next = count_reg + 1'b1;
                    state_next = dtq_pkg::ST_IDLE;
                end else begin
                    ram_re     = 1'b1;
                    ram_raddr  = dtq_pkg::ptr_dec(pos_reg);
                    state_next = dtq_pkg::ST_INS_CMP;
                end
            end

            dtq_pkg::ST_INS_CMP: begin
                // Move a later entry up one slot, or drop the new one in the gap
                ram_we = 1'b1;
                if (ram_rdata.wake_time > item_reg.wake_time) begin
                    ram_wdata  = ram_rdata;
                    pos_next   = dtq_pkg::ptr_dec(pos_reg);
                    rem_next   = rem_reg - 1'b1;
                    state_next = dtq_pkg::ST_INS_RD;
                end else begin
                    count_next = count_reg + 1'b1;
                    state_next = dtq_pkg::ST_IDLE;
                end
            end

            dtq_pkg::ST_TICK_RD: begin
                // Fetch the head while entries and result budget remain
                if (count_reg != '0 && res_cnt_reg < dtq_pkg::RES_W'(dtq_pkg::MAX_OUT)) begin
                    ram_re     = 1'b1;
                    state_next = dtq_pkg::ST_TICK_CHK;
                end else begin
                    state_next = dtq_pkg::ST_FLUSH;
                end
            end

            dtq_pkg::ST_TICK_CHK: begin
                // Release the head; push the held result out ahead of it
                if (!head_due) begin
                    state_next = dtq_pkg::ST_FLUSH;
                end else if (!pend_valid_reg || out_free) begin
                    out_load         = pend_valid_reg;
                    pend_valid_next  = 1'b1;
                    pend_handle_next = ram_rdata.stop ? '0 : ram_rdata.handle;
                    pend_status_next = ram_rdata.stop ? dtq_pkg::STATUS_STOP
                                                      : dtq_pkg::STATUS_DUE;
                    head_next        = dtq_pkg::ptr_inc(head_reg);
                    count_next       = count_reg - 1'b1;
                    res_cnt_next     = res_cnt_reg + 1'b1;
                    if (ram_rdata.stop) begin
                        halted_next = 1'b1;
                        state_next  = dtq_pkg::ST_FLUSH;
                    end else begin
                        state_next  = dtq_pkg::ST_TICK_RD;
                    end
                end
            end

            dtq_pkg::ST_FLUSH: begin
                // Send the held result as the last one of this transaction
                if (!pend_valid_reg) begin
                    state_next = dtq_pkg::ST_IDLE;
                end else if (out_free) begin
                    out_load        = 1'b1;
                    out_last        = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = dtq_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = dtq_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= dtq_pkg::ST_IDLE;
            head_reg       <= '0;
            count_reg      <= '0;
            halted_reg     <= 1'b0;
            pos_reg        <= '0;
            rem_reg        <= '0;
            res_cnt_reg    <= '0;
            pend_valid_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            count_reg      <= count_next;
            halted_reg     <= halted_next;
            pos_reg        <= pos_next;
            rem_reg        <= rem_next;
            res_cnt_reg    <= res_cnt_next;
            pend_valid_reg <= pend_valid_next;
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        item_reg        <= item_next;
        pend_handle_reg <= pend_handle_next;
        pend_status_reg <= pend_status_next;
        if (out_load) begin
            m_handle_reg <= out_handle;
            m_status_reg <= out_status;
            m_last_reg   <= out_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_handle_reg;
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;

`ifndef SYNTHESIS
    // Fill level never passes the buffer size
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= dtq_pkg::CNT_W'(dtq_pkg::QUEUE_DEPTH))
        else $error("entry count above queue depth");

    // Once halted, the block stays halted
    a_halt_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        halted_reg |=> halted_reg)
        else $error("halted flag cleared without reset");

    // RAM writes happen only while inserting
    a_write_in_insert: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == dtq_pkg::ST_INS_RD || state_reg == dtq_pkg::ST_INS_CMP))
        else $error("entry RAM written outside insertion");

    // A new transaction is never taken while a result is still held back
    a_accept_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !pend_valid_reg)
        else $error("input taken with a held result");

    // A stop result always closes its transaction
    a_stop_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == dtq_pkg::STATUS_STOP) |-> m_tlast)
        else $error("stop result without tlast");
`endif

endmodule

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the deadline timer queue core. Adds and ticks go in
// on the slave stream. Every accepted transaction goes through a local copy of
// the wakeup-ordered queue, and its releases and rejections are compared field
// by field against the master stream. A directed table opens the run. A random
// part follows, with several idle and stall mixes and one long receiver
// hold-off. A closing part releases a stop marker and halts the block.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import dtq_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;  // cycles with no transaction on either side
    localparam int HOLD_CYCLES    = 600;   // long receiver hold-off
    localparam int TAIL_CYCLES    = 100;
    localparam int PRINT_LIMIT    = 50;
    localparam int PHASE_ITEMS    = 42;

    // One result as it leaves the block
    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        status_t             status;
        logic                last;
    } release_t;

    // How a directed row is checked
    typedef enum {ROW_MODEL, ROW_NONE, ROW_ONE} row_check_t;

    typedef struct {
        logic                op;
        logic [TIME_W-1:0]   tval;
        logic [HANDLE_W-1:0] hnd;
        logic                stp;
        row_check_t          chk;
        logic [HANDLE_W-1:0] want_handle;
        status_t             want_status;
    } stim_row_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;   // [31:0] time_value, [47:32] op_handle
    logic [S_USER_W-1:0] s_tuser  = '0;   // [0] opcode, [1] stop_marker
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;         // [15:0] out_handle
    logic [M_USER_W-1:0] m_tuser;         // [1:0] status
    logic                m_tlast;

    // Predictor state: stored timers in wakeup order, and the halt flag
    entry_t      timer_entries[$];
    bit          stopped = 1'b0;
    release_t    step_releases[$];
    release_t    expected_releases[$];
    stim_row_t   dir_rows[$];
    int          closing_start;

    int unsigned idle_pct  = 0;
    int unsigned stall_pct = 0;
    int unsigned hold_events = 0;
    int unsigned mismatch_count = 0;

    deadline_timer_queue_core DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Free-running clock
    initial begin
        forever #10 aclk = ~aclk;
    end

    // Print one mismatch line and count it
    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT) begin
            $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
        end
    endtask

    // Work out the releases one accepted transaction causes, and update the queue
    function automatic void compute_releases(input logic op, input logic [TIME_W-1:0] tval,
                                             input logic [HANDLE_W-1:0] hnd, input logic stp);
        int       pos;
        entry_t   slot;
        release_t rel;
        step_releases.delete();
        if (stopped) begin
            return;
        end
        if (op == OP_ADD) begin
            // Reject on a full queue, otherwise insert behind equal wakeups
            if (timer_entries.size() >= QUEUE_DEPTH) begin
                rel.handle = hnd;
                rel.status = STATUS_FULL;
                rel.last   = 1'b1;
                step_releases.push_back(rel);
                return;
            end
            pos = timer_entries.size();
            while (pos > 0 && timer_entries[pos-1].wake_time > tval) begin
                pos--;
            end
            slot.wake_time = tval;
            slot.handle    = stp ? '0 : hnd;
            slot.stop      = stp;
            timer_entries.insert(pos, slot);
            return;
        end
        // Release due entries from the head; a stop marker halts regardless of time
        while (timer_entries.size() > 0 && step_releases.size() < MAX_OUT) begin
            slot = timer_entries[0];
            rel.last = 1'b0;
            if (slot.stop) begin
                rel.handle = '0;
                rel.status = STATUS_STOP;
                step_releases.push_back(rel);
                void'(timer_entries.pop_front());
                stopped = 1'b1;
                break;
            end
            if (slot.wake_time > tval) begin
                break;
            end
            rel.handle = slot.handle;
            rel.status = STATUS_DUE;
            step_releases.push_back(rel);
            void'(timer_entries.pop_front());
        end
        if (step_releases.size() > 0) begin
            step_releases[step_releases.size()-1].last = 1'b1;
        end
    endfunction

    // Offer one transaction, hold it until taken, then predict its results
    task automatic drive_item(input logic op, input logic [TIME_W-1:0] tval,
                              input logic [HANDLE_W-1:0] hnd, input logic stp,
                              input bit keep);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {hnd, tval};
        s_tuser  <= {stp, op};
        do @(posedge aclk); while (!s_tready);
        compute_releases(op, tval, hnd, stp);
        if (keep) begin
            foreach (step_releases[i]) expected_releases.push_back(step_releases[i]);
        end
    endtask

    function automatic void row(input logic op, input logic [TIME_W-1:0] tval,
                                input logic [HANDLE_W-1:0] hnd, input logic stp,
                                input row_check_t chk, input logic [HANDLE_W-1:0] wh,
                                input status_t ws);
        stim_row_t r;
        r.op = op; r.tval = tval; r.hnd = hnd; r.stp = stp;
        r.chk = chk; r.want_handle = wh; r.want_status = ws;
        dir_rows.push_back(r);
    endfunction

    // Apply one directed row; typed rows replace the prediction with their own
    task automatic apply_row(input stim_row_t r);
        release_t rel;
        drive_item(r.op, r.tval, r.hnd, r.stp, r.chk == ROW_MODEL);
        if (r.chk == ROW_ONE) begin
            rel.handle = r.want_handle;
            rel.status = r.want_status;
            rel.last   = 1'b1;
            expected_releases.push_back(rel);
        end
    endtask

    // Receiver: random stalls, plus a long hold-off when one is requested
    int unsigned hold_left  = 0;
    int unsigned hold_taken = 0;
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_taken != hold_events) begin
            m_tready   <= 1'b0;
            hold_taken <= hold_events;
            hold_left  <= HOLD_CYCLES;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Compare each result transaction with the oldest prediction
    always @(posedge aclk) begin
        release_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_releases.size() == 0) begin
                report_mismatch("unexpected result, handle", 32'(m_tdata), 0);
            end else begin
                want = expected_releases.pop_front();
                if (m_tdata !== want.handle) begin
                    report_mismatch("out_handle", 32'(m_tdata), 32'(want.handle));
                end
                if (m_tuser !== want.status) begin
                    report_mismatch("status", 32'(m_tuser), 32'(want.status));
                end
                if (m_tlast !== want.last) begin
                    report_mismatch("last", 32'(m_tlast), 32'(want.last));
                end
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    initial begin
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Stimulus
    initial begin
        int unsigned idle_mix[4]  = '{0, 63, 0, 13};
        int unsigned stall_mix[4] = '{0, 0, 63, 13};
        logic [TIME_W-1:0]   now_time;
        logic [TIME_W-1:0]   tval;
        logic [HANDLE_W-1:0] hnd;
        int unsigned         sel;

        // Empty queue, fill to the brim with equal and extreme wakeups, reject, drain
        row(OP_TICK, 32'h0000_0000, 16'h0000, 1'b0, ROW_NONE, '0, STATUS_DUE);
        row(OP_TICK, 32'hFFFF_FFFF, 16'hFFFF, 1'b0, ROW_NONE, '0, STATUS_DUE);
        row(OP_ADD,  32'hFFFF_FFFF, 16'hFFFF, 1'b0, ROW_NONE, '0, STATUS_DUE);
        row(OP_ADD,  32'h0000_0000, 16'h0000, 1'b0, ROW_NONE, '0, STATUS_DUE);
        row(OP_ADD,  32'h0000_0005, 16'h1234, 1'b0, ROW_NONE, '0, STATUS_DUE);
        row(OP_ADD,  32'h0000_0005, 16'h4321, 1'b0, ROW_NONE, '0, STATUS_DUE);
        row(OP_ADD,  32'h8000_0000, 16'h8000, 1'b0, ROW_NONE, '0, STATUS_DUE);
        row(OP_ADD,  32'h0000_0003, 16'h0003, 1'b0, ROW_NONE, '0, STATUS_DUE);
        row(OP_ADD,  32'h0000_0005, 16'h5555, 1'b0, ROW_NONE, '0, STATUS_DUE);
        row(OP_ADD,  32'h7FFF_FFFF, 16'h7FFF, 1'b0, ROW_NONE, '0, STATUS_DUE);
        row(OP_ADD,  32'h0000_0001, 16'h0001, 1'b0, ROW_NONE, '0, STATUS_DUE);
        row(OP_ADD,  32'hFFFF_FFFF, 16'hFFFE, 1'b0, ROW_NONE, '0, STATUS_DUE);
        row(OP_ADD,  32'h0000_0002, 16'h0002, 1'b0, ROW_NONE, '0, STATUS_DUE);
        row(OP_ADD,  32'h0000_0005, 16'h0005, 1'b0, ROW_NONE, '0, STATUS_DUE);
        row(OP_ADD,  32'h0000_0040, 16'h0040, 1'b0, ROW_NONE, '0, STATUS_DUE);
        row(OP_ADD,  32'h0000_0010, 16'h0010, 1'b0, ROW_NONE, '0, STATUS_DUE);
        row(OP_ADD,  32'h0000_0020, 16'h0020, 1'b0, ROW_NONE, '0, STATUS_DUE);
        row(OP_ADD,  32'h0000_0000, 16'hA5A5, 1'b0, ROW_NONE, '0, STATUS_DUE);
        row(OP_ADD,  32'h0000_0001, 16'hBEEF, 1'b0, ROW_ONE, 16'hBEEF, STATUS_FULL);
        row(OP_TICK, 32'hFFFF_FFFF, 16'h0000, 1'b0, ROW_MODEL, '0, STATUS_DUE);
        row(OP_ADD,  32'h0000_0007, 16'hAAAA, 1'b0, ROW_NONE, '0, STATUS_DUE);
        row(OP_TICK, 32'h0000_0006, 16'h0000, 1'b0, ROW_NONE, '0, STATUS_DUE);
        row(OP_TICK, 32'h0000_0007, 16'h0000, 1'b0, ROW_ONE, 16'hAAAA, STATUS_DUE);
        closing_start = dir_rows.size();
        // Drain, then a stop marker behind a due entry and a later one; stop halts
        row(OP_TICK, 32'hFFFF_FFFF, 16'h0000, 1'b0, ROW_MODEL, '0, STATUS_DUE);
        row(OP_ADD,  32'h0000_0010, 16'h5555, 1'b0, ROW_NONE, '0, STATUS_DUE);
        row(OP_ADD,  32'hFFFF_FFFF, 16'hABCD, 1'b1, ROW_NONE, '0, STATUS_DUE);
        row(OP_ADD,  32'hFFFF_FFFE, 16'h0007, 1'b0, ROW_NONE, '0, STATUS_DUE);
        row(OP_TICK, 32'h0000_0020, 16'h0000, 1'b0, ROW_ONE, 16'h5555, STATUS_DUE);
        row(OP_TICK, 32'hFFFF_FFFE, 16'h0000, 1'b0, ROW_MODEL, '0, STATUS_DUE);
        row(OP_ADD,  32'h0000_0000, 16'h0001, 1'b0, ROW_NONE, '0, STATUS_DUE);
        row(OP_TICK, 32'hFFFF_FFFF, 16'h0000, 1'b0, ROW_NONE, '0, STATUS_DUE);

        // Hold reset, then release it
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed opening
        idle_pct  = 13;
        stall_pct = 13;
        for (int i = 0; i < closing_start; i++) begin
            apply_row(dir_rows[i]);
        end

        // Random: adds near the running time, ticks that advance it, few outliers
        now_time = '0;
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct  = idle_mix[ph];
            stall_pct = stall_mix[ph];
            if (ph == 0) begin
                hold_events++;
            end
            repeat (PHASE_ITEMS) begin
                hnd = HANDLE_W'($urandom);
                sel = $urandom_range(9);
                if ($urandom_range(99) < 55) begin
                    if (sel == 0) begin
                        tval = $urandom;
                    end else if (sel == 1) begin
                        tval = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0000_0000;
                    end else begin
                        tval = now_time + $urandom_range(60);
                    end
                    drive_item(OP_ADD, tval, hnd, 1'b0, 1'b1);
                end else begin
                    if (sel < 8) begin
                        now_time = now_time + $urandom_range(40);
                        tval = now_time;
                    end else if (sel == 8) begin
                        tval = $urandom;
                    end else begin
                        tval = 32'hFFFF_FFFF;
                    end
                    drive_item(OP_TICK, tval, hnd, 1'($urandom_range(1)), 1'b1);
                end
            end
        end

        // Closing rows: drain, stop marker, halted block
        idle_pct  = 13;
        stall_pct = 13;
        for (int i = closing_start; i < dir_rows.size(); i++) begin
            apply_row(dir_rows[i]);
        end
        s_tvalid <= 1'b0;

        // Wait for outstanding results, then watch for strays
        while (expected_releases.size() > 0) begin
            @(posedge aclk);
        end
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

### sim.f
rtl/dtq_pkg.sv
rtl/dtq_ram.sv
rtl/deadline_timer_queue_core.sv
bench/tb_top.sv
